@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk, reset on arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`define ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

@@ design/fcrr_pkg.sv @@
// ----------------------------------------------------------------------------
// fcrr_pkg
// Types and constants shared by the FAT chain run reader modules.
// ----------------------------------------------------------------------------
package fcrr_pkg;

	localparam int unsigned SECTOR_BYTES_DEF = 512;
	localparam logic [16:0] CLUSTER_SIZE_RST = 17'd512;
	localparam logic [31:0] MIN_CLUSTER      = 32'd2;

	// result kinds
	localparam logic [1:0] KIND_WHOLE = 2'd0;
	localparam logic [1:0] KIND_TAIL  = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// config register indexes
	localparam logic [1:0] REG_CLUSTER_SIZE = 2'd0;
	localparam logic [1:0] REG_FILE_SIZE    = 2'd1;

	typedef enum logic [2:0] {
		EMIT_ERROR,
		EMIT_DONE_ZERO,
		EMIT_DONE_COPIED,
		EMIT_WHOLE,
		EMIT_TAIL
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		logic      clear;
		logic      finish;
		logic      open_run;
		logic      extend_run;
		logic      mul;
		logic      close_run;
		logic      add_whole;
		logic      add_tail;
		logic      emit;
		emit_sel_t sel;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic size_ok;
		logic fs_zero;
		logic finished;
		logic run_open;
		logic open_done;
		logic lba_zero;
		logic cont;
		logic has_whole;
		logic has_tail;
		logic done_end;
		logic out_free;
	} sts_t;

endpackage

@@ design/fat_chain_run_reader_unit.sv @@
// ----------------------------------------------------------------------------
// fat_chain_run_reader_unit
// Coalesces FAT chain entries into sector read requests for one file.
// ----------------------------------------------------------------------------
// Feed the chain entries of a file in chain order, start_read set on the
// first. Consecutive clusters merge into a run that stops at the clusters the
// file still needs; a closing run issues a whole-sector read request, then a
// tail read request for leftover bytes, each with its buffer offset, and a
// done result (bytes copied) ends the read. Errors: bad cluster size, zero
// sector on a run start. The sequencer walks each entry through capture,
// check, run update, the registered run length times cluster size product
// and the run-close compare, then one step per request, each of which may
// wait on out_ready; an entry that ends the read before a run is touched
// stops after the check or the run update.
// A new entry is taken while the last result still waits in the output
// register. Configuration writes are always ready and must only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module fat_chain_run_reader_unit #(
	parameter int unsigned SECTOR_BYTES = fcrr_pkg::SECTOR_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// chain entry channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        start_read,
	input  logic [31:0] cluster_number,
	input  logic        cluster_is_end,
	input  logic [31:0] cluster_sector,
	input  logic [31:0] link_cluster,
	input  logic        link_is_end,
	// request / result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [31:0] request_lba,
	output logic [23:0] request_count,
	output logic [31:0] buffer_offset,
	output logic        last_result
);

	fcrr_pkg::cmd_t cmd;
	fcrr_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	fcrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fcrr_dp #(
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start_read     (start_read),
		.cluster_number (cluster_number),
		.cluster_is_end (cluster_is_end),
		.cluster_sector (cluster_sector),
		.link_cluster   (link_cluster),
		.link_is_end    (link_is_end),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.request_lba    (request_lba),
		.request_count  (request_count),
		.buffer_offset  (buffer_offset),
		.last_result    (last_result)
	);

endmodule

@@ design/fcrr_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcrr_ctrl
// Sequencer: walks one chain entry through check, run update, close, emit.
// ----------------------------------------------------------------------------
module fcrr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fcrr_pkg::sts_t sts,
	output fcrr_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_OPEN, S_MUL, S_DECIDE, S_WHOLE, S_TAIL, S_FIN
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd      = '0;
		cmd.sel  = fcrr_pkg::EMIT_ERROR;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!sts.start) begin
					state_d = S_OPEN;
				end else if (sts.out_free) begin
					cmd.clear = 1'b1;
					if (!sts.size_ok) begin
						cmd.emit = 1'b1; cmd.finish = 1'b1;
						cmd.sel  = fcrr_pkg::EMIT_ERROR;
						state_d  = S_IDLE;
					end else if (sts.fs_zero) begin
						cmd.emit = 1'b1; cmd.finish = 1'b1;
						cmd.sel  = fcrr_pkg::EMIT_DONE_ZERO;
						state_d  = S_IDLE;
					end else begin
						state_d = S_OPEN;
					end
				end
			end
			S_OPEN: begin
				if (sts.finished) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					if (!sts.size_ok) begin
						cmd.emit = 1'b1; cmd.finish = 1'b1;
						cmd.sel  = fcrr_pkg::EMIT_ERROR;
						state_d  = S_IDLE;
					end else if (sts.run_open) begin
						cmd.extend_run = 1'b1;
						state_d        = S_MUL;
					end else if (sts.open_done) begin
						cmd.emit = 1'b1; cmd.finish = 1'b1;
						cmd.sel  = fcrr_pkg::EMIT_DONE_COPIED;
						state_d  = S_IDLE;
					end else if (sts.lba_zero) begin
						cmd.emit = 1'b1; cmd.finish = 1'b1;
						cmd.sel  = fcrr_pkg::EMIT_ERROR;
						state_d  = S_IDLE;
					end else begin
						cmd.open_run = 1'b1;
						state_d      = S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.cont) begin
					state_d = S_IDLE;
				end else begin
					cmd.close_run = 1'b1;
					state_d       = S_WHOLE;
				end
			end
			S_WHOLE: begin
				if (!sts.has_whole) begin
					state_d = S_TAIL;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1; cmd.add_whole = 1'b1;
					cmd.sel  = fcrr_pkg::EMIT_WHOLE;
					state_d  = S_TAIL;
				end
			end
			S_TAIL: begin
				if (!sts.has_tail) begin
					state_d = S_FIN;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1; cmd.add_tail = 1'b1;
					cmd.sel  = fcrr_pkg::EMIT_TAIL;
					state_d  = S_FIN;
				end
			end
			S_FIN: begin
				if (!sts.done_end) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1; cmd.finish = 1'b1;
					cmd.sel  = fcrr_pkg::EMIT_DONE_COPIED;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/fcrr_dp.sv @@
// ----------------------------------------------------------------------------
// fcrr_dp
// Datapath: config, entry capture, run state, run product, output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcrr_dp #(
	parameter int unsigned SECTOR_BYTES = fcrr_pkg::SECTOR_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        start_read,
	input  logic [31:0] cluster_number,
	input  logic        cluster_is_end,
	input  logic [31:0] cluster_sector,
	input  logic [31:0] link_cluster,
	input  logic        link_is_end,
	input  fcrr_pkg::cmd_t cmd,
	output fcrr_pkg::sts_t sts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [31:0] request_lba,
	output logic [23:0] request_count,
	output logic [31:0] buffer_offset,
	output logic        last_result
);

	localparam int unsigned SB_W = $clog2(SECTOR_BYTES);

	logic [16:0] cs_q;
	logic [31:0] fs_q;
	logic        start_q, cl_end_q, link_end_q;
	logic [31:0] cl_q, lba_q, link_q;
	logic [31:0] first_q, len_q, slba_q, bc_q;
	logic        open_q, fin_q;
	logic [48:0] prod_s1;
	logic [23:0] whole_q, tail_q;
	logic        done_end_q, last_whole_q, last_tail_q;
	logic        out_valid_q;

	logic [31:0] remaining, run_span, bytes_sum;
	logic [23:0] whole_c, tail_c;
	logic        size_ok, done_end_c, out_free;

	assign size_ok   = (cs_q != '0) && (cs_q[SB_W-1:0] == '0);
	assign remaining = (fs_q > bc_q) ? (fs_q - bc_q) : '0;
	// product below remaining means fewer clusters than the file still needs
	assign run_span  = (prod_s1 < {17'd0, remaining}) ? prod_s1[31:0] : remaining;
	assign whole_c   = 24'(run_span >> SB_W);
	assign tail_c    = 24'(run_span & 32'(SECTOR_BYTES - 1));
	assign bytes_sum = bc_q + run_span;
	assign done_end_c = link_end_q || (link_q < fcrr_pkg::MIN_CLUSTER) || (bytes_sum >= fs_q);
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		sts.start     = start_q;
		sts.size_ok   = size_ok;
		sts.fs_zero   = (fs_q == '0);
		sts.finished  = fin_q;
		sts.run_open  = open_q;
		sts.open_done = cl_end_q || (cl_q < fcrr_pkg::MIN_CLUSTER) || (remaining == '0);
		sts.lba_zero  = (lba_q == '0);
		sts.cont      = (prod_s1 < {17'd0, remaining}) && !link_end_q &&
		                (link_q == first_q + len_q);
		sts.has_whole = (whole_q != '0);
		sts.has_tail  = (tail_q != '0);
		sts.done_end  = done_end_q;
		sts.out_free  = out_free;
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= fcrr_pkg::CLUSTER_SIZE_RST;
			fs_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == fcrr_pkg::REG_CLUSTER_SIZE) cs_q <= cfg_data[16:0];
			if (cfg_index == fcrr_pkg::REG_FILE_SIZE)    fs_q <= cfg_data;
		end
	end

	// entry capture, product and close results (payload, no reset)
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q    <= start_read;
			cl_q       <= cluster_number;
			cl_end_q   <= cluster_is_end;
			lba_q      <= cluster_sector;
			link_q     <= link_cluster;
			link_end_q <= link_is_end;
		end
		if (cmd.mul) prod_s1 <= len_q * {15'd0, cs_q};
		if (cmd.close_run) begin
			whole_q      <= whole_c;
			tail_q       <= tail_c;
			done_end_q   <= done_end_c;
			last_whole_q <= (tail_c == '0) && !done_end_c;
			last_tail_q  <= !done_end_c;
		end
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			len_q   <= '0;
			slba_q  <= '0;
			bc_q    <= '0;
			open_q  <= 1'b0;
			fin_q   <= 1'b1;
		end else begin
			if (cmd.clear) begin
				first_q <= '0;
				len_q   <= '0;
				slba_q  <= '0;
				bc_q    <= '0;
			end else if (cmd.open_run) begin
				first_q <= cl_q;
				len_q   <= 32'd1;
				slba_q  <= lba_q;
			end else if (cmd.extend_run) begin
				len_q <= len_q + 32'd1;
			end else if (cmd.add_whole) begin
				bc_q <= bc_q + (32'(whole_q) << SB_W);
			end else if (cmd.add_tail) begin
				bc_q <= bc_q + 32'(tail_q);
			end
			// finish wins over the clear of a start that ends at once
			if (cmd.finish) begin
				fin_q  <= 1'b1;
				open_q <= 1'b0;
			end else if (cmd.clear) begin
				fin_q  <= 1'b0;
				open_q <= 1'b0;
			end else if (cmd.open_run) begin
				open_q <= 1'b1;
			end else if (cmd.close_run) begin
				open_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique case (cmd.sel)
				fcrr_pkg::EMIT_WHOLE: begin
					result_kind   <= fcrr_pkg::KIND_WHOLE;
					request_lba   <= slba_q;
					request_count <= whole_q;
					buffer_offset <= bc_q;
					last_result   <= last_whole_q;
				end
				fcrr_pkg::EMIT_TAIL: begin
					result_kind   <= fcrr_pkg::KIND_TAIL;
					request_lba   <= slba_q + 32'(whole_q);
					request_count <= tail_q;
					buffer_offset <= bc_q;
					last_result   <= last_tail_q;
				end
				fcrr_pkg::EMIT_DONE_COPIED: begin
					result_kind   <= fcrr_pkg::KIND_DONE;
					request_lba   <= '0;
					request_count <= '0;
					buffer_offset <= bc_q;
					last_result   <= 1'b1;
				end
				fcrr_pkg::EMIT_DONE_ZERO: begin
					result_kind   <= fcrr_pkg::KIND_DONE;
					request_lba   <= '0;
					request_count <= '0;
					buffer_offset <= '0;
					last_result   <= 1'b1;
				end
				default: begin
					result_kind   <= fcrr_pkg::KIND_ERROR;
					request_lba   <= '0;
					request_count <= '0;
					buffer_offset <= '0;
					last_result   <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_IMPLY(a_emit_slot_free, cmd.emit, out_free)
	`ASSERT_IMPLY(a_finished_no_run, fin_q, !open_q)
	`ASSERT_IMPLY(a_open_run_len, open_q, len_q != '0)

endmodule

@@ bench/fcrr_chain_checker.sv @@
// ----------------------------------------------------------------------------
// fcrr_chain_checker
// Watches the config, chain entry and request channels of the run reader,
// predicts the requests each accepted entry causes and compares them in order.
// ----------------------------------------------------------------------------
module fcrr_chain_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        start_read,
	input  logic [31:0] cluster_number,
	input  logic        cluster_is_end,
	input  logic [31:0] cluster_sector,
	input  logic [31:0] link_cluster,
	input  logic        link_is_end,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  result_kind,
	input  logic [31:0] request_lba,
	input  logic [23:0] request_count,
	input  logic [31:0] buffer_offset,
	input  logic        last_result,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] SECTOR = 32'd512;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] lba;
		logic [23:0] count;
		logic [31:0] offset;
		logic        last;
	} read_req_t;

	read_req_t req_q[$];

	// mirrored registers and progress
	logic [16:0] cl_size = fcrr_pkg::CLUSTER_SIZE_RST;
	logic [31:0] f_size = '0;
	logic [31:0] first_cl = '0;
	logic [31:0] run_len = '0;
	logic [31:0] start_lba = '0;
	logic [31:0] copied = '0;
	bit          in_run = 0;
	bit          finished = 1;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic push_req(input logic [1:0] k, input logic [31:0] l,
			input logic [31:0] c, input logic [31:0] o);
		read_req_t r;
		r.kind = k; r.lba = l; r.count = c[23:0]; r.offset = o; r.last = 1'b0;
		req_q.push_back(r);
	endtask

	task automatic finish_read(input logic [1:0] k, input logic [31:0] o);
		push_req(k, '0, '0, o);
		req_q[$].last = 1'b1;
		finished = 1;
		in_run = 0;
	endtask

	task automatic predict_entry(input bit st, input logic [31:0] cl, input bit cle,
			input logic [31:0] lba, input logic [31:0] link, input bit le);
		logic [31:0] remaining, needed, run_span, whole, tail;
		logic [63:0] held;
		bit size_good;
		int n;
		n = 0;
		size_good = (cl_size != 0) && (cl_size[8:0] == 0);
		if (st) begin
			copied = '0; in_run = 0; finished = 0;
			first_cl = '0; run_len = '0; start_lba = '0;
			if (!size_good) begin finish_read(fcrr_pkg::KIND_ERROR, '0); return; end
			if (f_size == 0) begin finish_read(fcrr_pkg::KIND_DONE, '0); return; end
		end
		if (finished) return;
		if (!size_good) begin finish_read(fcrr_pkg::KIND_ERROR, '0); return; end
		remaining = (f_size > copied) ? f_size - copied : '0;
		if (!in_run) begin
			if (cle || cl < fcrr_pkg::MIN_CLUSTER || remaining == 0) begin
				finish_read(fcrr_pkg::KIND_DONE, copied);
				return;
			end
			if (lba == 0) begin finish_read(fcrr_pkg::KIND_ERROR, '0); return; end
			in_run = 1; first_cl = cl; run_len = 32'd1; start_lba = lba;
		end else
			run_len = run_len + 32'd1;
		needed = (remaining == 0) ? '0 : (remaining - 1) / {15'd0, cl_size} + 1;
		if (run_len < needed && !le && link == first_cl + run_len) return;
		// run closes
		in_run = 0;
		held = 64'(run_len) * 64'(cl_size);
		run_span = (held < 64'(remaining)) ? held[31:0] : remaining;
		whole = run_span / SECTOR;
		tail = run_span % SECTOR;
		if (64'(whole) > 64'(run_len) * 64'(cl_size / 17'd512)) begin
			finish_read(fcrr_pkg::KIND_ERROR, '0);
			return;
		end
		if (whole > 0) begin
			push_req(fcrr_pkg::KIND_WHOLE, start_lba, whole, copied);
			copied = copied + whole * SECTOR;
			n++;
		end
		if (tail > 0) begin
			push_req(fcrr_pkg::KIND_TAIL, start_lba + whole, tail, copied);
			copied = copied + tail;
			n++;
		end
		if (le || link < fcrr_pkg::MIN_CLUSTER || copied >= f_size) begin
			finish_read(fcrr_pkg::KIND_DONE, copied);
			return;
		end
		if (n > 0) req_q[$].last = 1'b1;
	endtask

	always @(posedge clk) begin
		read_req_t w;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == fcrr_pkg::REG_CLUSTER_SIZE) cl_size = cfg_data[16:0];
				else if (cfg_index == fcrr_pkg::REG_FILE_SIZE) f_size = cfg_data;
			end
			// compare before predicting: an entry accepted now cannot have a result out yet
			if (out_valid && out_ready) begin
				if (req_q.size() == 0) begin
					report_mismatch("unexpected request kind", 32'(result_kind), '0);
				end else begin
					w = req_q.pop_front();
					if (result_kind !== w.kind)
						report_mismatch("kind", 32'(result_kind), 32'(w.kind));
					if (request_lba !== w.lba) report_mismatch("lba", request_lba, w.lba);
					if (request_count !== w.count)
						report_mismatch("count", 32'(request_count), 32'(w.count));
					if (buffer_offset !== w.offset)
						report_mismatch("offset", buffer_offset, w.offset);
					if (last_result !== w.last)
						report_mismatch("last", 32'(last_result), 32'(w.last));
				end
			end
			if (in_valid && in_ready)
				predict_entry(start_read, cluster_number, cluster_is_end, cluster_sector,
					link_cluster, link_is_end);
			pending = req_q.size();
		end
	end
endmodule

@@ bench/fat_chain_run_reader_unit_tb.sv @@
// ----------------------------------------------------------------------------
// fat_chain_run_reader_unit_tb
// Drives directed and random FAT chains through the run reader under varied
// idle and stall patterns; a checker module predicts and compares requests.
// ----------------------------------------------------------------------------
module fat_chain_run_reader_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;   // cycles with no request accepted anywhere
	localparam int HOLD_CYCLES = 400;     // long receiver hold-off
	localparam int SETTLE = 20;           // block latency margin before config

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0, cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 0, in_ready;
	logic        start_read = 0, cluster_is_end = 0, link_is_end = 0;
	logic [31:0] cluster_number = '0, cluster_sector = '0, link_cluster = '0;
	logic        out_valid, out_ready = 0;
	logic [1:0]  result_kind;
	logic [31:0] request_lba, buffer_offset;
	logic [23:0] request_count;
	logic        last_result;
	int          fail_count, pending;

	int  send_idle = 0;    // percent of cycles the sender stays idle
	int  recv_stall = 0;   // percent of cycles the receiver stalls
	bit  hold_go = 0;
	int  idle_cycles = 0;
	int  items = 0;

	initial forever #5 clk = ~clk;

	fat_chain_run_reader_unit u_dut (.*);

	fcrr_chain_checker u_chk (.*);

	// watchdog: ends the run if the channels go quiet for too long
	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("fat_chain_run_reader_unit_tb NOT OK");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial forever begin
		@(negedge clk);
		if (hold_go) begin
			hold_go = 0;
			out_ready = 0;
			repeat (HOLD_CYCLES) @(negedge clk);
		end
		out_ready = ($urandom_range(0, 99) >= recv_stall);
	end

	// wait until every predicted request has come, then let the block settle
	task automatic drain();
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		drain();
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// offer one chain entry; valid stays up afterwards unless a gap follows
	task automatic entry(input bit st, input logic [31:0] cl, input bit cle,
			input logic [31:0] lba, input logic [31:0] link, input bit le);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid = 0;
			@(negedge clk);
		end
		start_read = st;
		cluster_number = cl;
		cluster_is_end = cle;
		cluster_sector = lba;
		link_cluster = link;
		link_is_end = le;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic idle_sender();
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic set_phase(input int p);
		case (p)
			0: begin send_idle = 0; recv_stall = 0; end
			1: begin send_idle = 72; recv_stall = 0; end
			2: begin send_idle = 0; recv_stall = 72; end
			default: begin send_idle = 26; recv_stall = 26; end
		endcase
	endtask

	// one random file read: mostly well-formed chains, some broken links
	task automatic random_file();
		logic [31:0] cs, fs, cur, nxt, lba;
		int k, r;
		r = $urandom_range(0, 99);
		if (r < 8) cs = $urandom_range(0, 17'h1FFFF);          // often a bad size
		else if (r < 12) cs = 65536;
		else if (r < 50) cs = 512 << $urandom_range(0, 3);
		else cs = 512 * $urandom_range(1, 128);
		r = $urandom_range(0, 99);
		if (r < 5) fs = 0;
		else if (r < 12) fs = $urandom;
		else fs = $urandom_range(1, cs * 6 + 1);
		write_reg(fcrr_pkg::REG_CLUSTER_SIZE, cs);
		write_reg(fcrr_pkg::REG_FILE_SIZE, fs);
		k = $urandom_range(1, 6);
		cur = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
		for (int i = 0; i < k; i++) begin
			nxt = ($urandom_range(0, 99) < 75) ? cur + 1 : $urandom;
			lba = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
			entry(i == 0, cur, $urandom_range(0, 24) == 0, lba, nxt,
				(i == k - 1) ? 1'b1 : ($urandom_range(0, 19) == 0));
			items++;
			cur = nxt;
		end
		// occasional noise entry with start low
		if ($urandom_range(0, 9) == 0)
			entry(1'b0, $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom,
				1'($urandom_range(0, 1)));
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1;
		set_phase(0);

		// ignored while finished after reset, then zero file size
		entry(0, 32'd5, 0, 32'd9, 32'd6, 0);
		entry(1, 32'd5, 0, 32'd9, 32'd6, 0);
		idle_sender();
		// two-cluster run saturated to the file: whole plus tail plus done
		write_reg(fcrr_pkg::REG_FILE_SIZE, 32'd1000);
		entry(1, 32'd2, 0, 32'd100, 32'd3, 0);
		entry(0, 32'd3, 0, 32'd0, 32'hFFFF_FFFF, 1);
		idle_sender();
		// bad cluster sizes
		write_reg(fcrr_pkg::REG_CLUSTER_SIZE, 32'd0);
		entry(1, 32'd2, 0, 32'd1, 32'd3, 0);
		idle_sender();
		write_reg(fcrr_pkg::REG_CLUSTER_SIZE, 32'd100);
		entry(1, 32'd2, 0, 32'd1, 32'd3, 0);
		idle_sender();
		// largest file size, 65536-byte clusters: end mark, cluster below 2, sector zero on run start
		write_reg(fcrr_pkg::REG_CLUSTER_SIZE, 32'd65536);
		write_reg(fcrr_pkg::REG_FILE_SIZE, 32'hFFFF_FFFF);
		entry(1, 32'hFFFF_FFFF, 1, 32'd7, 32'd0, 0);
		entry(1, 32'd1, 0, 32'd7, 32'd0, 0);
		entry(1, 32'd0, 0, 32'd7, 32'd0, 0);
		entry(1, 32'd40, 0, 32'd0, 32'd41, 0);
		// start while a run is open, address wrap, cluster below 2 ends the read
		entry(1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFF0, 32'd0, 0);
		entry(1, 32'hFFFF_FFFE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		entry(0, 32'd0, 0, 32'd0, 32'd0, 0);
		entry(0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'h1234_5678, 0);
		entry(0, 32'd0, 0, 32'd0, 32'd1, 0);
		idle_sender();

		// long receiver hold-off while a jumping chain fills the block
		write_reg(fcrr_pkg::REG_CLUSTER_SIZE, 32'd512);
		write_reg(fcrr_pkg::REG_FILE_SIZE, 32'd100000);
		hold_go = 1;
		entry(1, 32'd10, 0, 32'd500, 32'd20, 0);
		for (int i = 1; i < 10; i++)
			entry(0, 32'd10 * i, 0, 32'd0, 32'd10 * (i + 1) + 5, i == 9);
		idle_sender();

		// random part across idle phases, pausing on every file boundary
		items = 0;
		while (items < 85) begin
			set_phase((items / 22) % 4);
			random_file();
			idle_sender();
		end

		drain();
		repeat (SETTLE) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("fat_chain_run_reader_unit_tb OK");
		end else begin
			$display("fat_chain_run_reader_unit_tb NOT OK");
		end
		$finish;
	end
endmodule
